### rtl/khe_pkg.sv
// Shared types and constants for the key hash engine.
package khe_pkg;

	typedef logic [31:0] key_t;

	typedef enum logic [1:0] {
		MODE_INT   = 2'd0,
		MODE_BYTE  = 2'd1,
		MODE_EMPTY = 2'd2
	} mode_t;

	localparam key_t CRC_POLY    = 32'hEDB8_8320;
	localparam key_t GOLDEN_MULT = 32'd2654435761;

endpackage

### rtl/khe_front.sv
// Front end: accepts items, runs the byte-wise CRC and queues finished keys.
module khe_front import khe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] key_value,
	input  logic [7:0]  key_byte,
	input  logic        last_byte,
	input  logic        q_full,
	output logic        q_push,
	output key_t        q_key
);

	key_t crc_q;
	key_t crc_next;
	logic accept;

	function automatic key_t crc_step(input key_t crc_in, input logic [7:0] b);
		key_t c;
		c = crc_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign crc_next = crc_step(crc_q, key_byte);

	always_comb begin
		q_push = 1'b0;
		q_key  = '0;
		case (mode_t'(mode))
			MODE_INT: begin
				q_push = accept;
				q_key  = key_value;
			end
			MODE_BYTE: begin
				q_push = accept && last_byte;
				q_key  = crc_next;
			end
			MODE_EMPTY: begin
				q_push = accept;
				q_key  = '0;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// An integer key leaves a string in progress untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (accept) begin
			case (mode_t'(mode))
				MODE_BYTE:  crc_q <= last_byte ? '0 : crc_next;
				MODE_EMPTY: crc_q <= '0;
				default:    crc_q <= crc_q;
			endcase
		end
	end

endmodule

### rtl/khe_fifo.sv
// Short queue of finished keys between front and back end.
module khe_fifo import khe_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  key_t push_key,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output key_t pop_key
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	key_t            mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign full     = (count_q == CntW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_key  = mem[rd_ptr_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/khe_back.sv
// Back end: mix rounds and golden-ratio multiply, ending in the result register.
module khe_back import khe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  key_t        q_key,
	output logic        q_pop,
	input  key_t        index_mask_q,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value,
	output logic [31:0] bucket_index
);

	key_t mix_s1, mix_s2, hash_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic adv1, adv2, adv3;
	key_t mix_a, mix_b, prod;

	function automatic key_t mix_first(input key_t k);
		key_t v;
		v = k + (k << 12);
		v = v ^ (v >> 22);
		v = v + (v << 4);
		v = v ^ (v >> 9);
		return v;
	endfunction

	function automatic key_t mix_second(input key_t k);
		key_t v;
		v = k + (k << 10);
		v = v ^ (v >> 2);
		v = v + (v << 7);
		v = v ^ (v >> 12);
		return v;
	endfunction

	// A stage moves on when it is empty or the one after it moves
	assign adv3  = !vld_s3 || out_ready;
	assign adv2  = !vld_s2 || adv3;
	assign adv1  = !vld_s1 || adv2;
	assign q_pop = q_nonempty && adv1;

	assign mix_a = mix_first(q_key);
	assign mix_b = mix_second(mix_s1);
	assign prod  = key_t'({3'd0, mix_s2[31:3]} * GOLDEN_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= q_nonempty;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) mix_s1  <= mix_a;
		if (adv2) mix_s2  <= mix_b;
		if (adv3) hash_s3 <= prod;
	end

	assign out_valid    = vld_s3;
	assign hash_value   = hash_s3;
	assign bucket_index = hash_s3 & index_mask_q;

endmodule

### rtl/key_hash_engine.sv
// Hash table key hasher: integer keys and byte-streamed string keys in, hash and bucket out.
// Takes one transaction per cycle unless the queue is full, string bytes and integer keys alike;
// a string byte that is not the last one only advances the running CRC, and every other accepted
// item of a defined mode gives one result. The CRC of a byte is worked out in the cycle the byte
// is accepted; the finished key then waits in a FIFO_DEPTH-entry queue and passes through three
// back-end registers (two mix stages and the multiply, the last being the result register).
// Front and back stall independently: input ready drops only when the queue is full.
// Write index_mask only while no results are outstanding.
module key_hash_engine import khe_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] key_value,
	input  logic [7:0]  key_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value,
	output logic [31:0] bucket_index
);

	key_t index_mask_q;
	logic q_push, q_full, q_pop, q_nonempty;
	key_t q_push_key, q_pop_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_mask_q <= '0;
		end else if (cfg_we) begin
			index_mask_q <= cfg_wdata;
		end
	end

	khe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.key_value (key_value),
		.key_byte  (key_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_key     (q_push_key)
	);

	khe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_key (q_push_key),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.pop_key  (q_pop_key)
	);

	khe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_key        (q_pop_key),
		.q_pop        (q_pop),
		.index_mask_q (index_mask_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value),
		.bucket_index (bucket_index)
	);

endmodule
